[src/sbb_pkg.sv]
// Shared types, constants and reciprocal table for the separable box blur.
`timescale 1ns / 1ps
package sbb_pkg;

   localparam int REG_W       = 11;
   localparam int PIX_W       = 24;
   localparam int RECIP_W     = 19;
   localparam int RECIP_SHIFT = 18;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DREAD,
      ST_HSUM,
      ST_HDIV,
      ST_VSUM,
      ST_VDIV,
      ST_OUT
   } state_type;

   // ceil(2^18 / n): exact floor quotient for sums up to 17 * 255
   function automatic logic [RECIP_W-1:0] recip_value(input logic [4:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         5'd1:    m = 19'd262144;
         5'd2:    m = 19'd131072;
         5'd3:    m = 19'd87382;
         5'd4:    m = 19'd65536;
         5'd5:    m = 19'd52429;
         5'd6:    m = 19'd43691;
         5'd7:    m = 19'd37450;
         5'd8:    m = 19'd32768;
         5'd9:    m = 19'd29128;
         5'd10:   m = 19'd26215;
         5'd11:   m = 19'd23832;
         5'd12:   m = 19'd21846;
         5'd13:   m = 19'd20165;
         5'd14:   m = 19'd18725;
         5'd15:   m = 19'd17477;
         5'd16:   m = 19'd16384;
         5'd17:   m = 19'd15421;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

[src/sbb_mean.sv]
// Three-channel truncated mean: sum times reciprocal of the sample count, registered.
`timescale 1ns / 1ps
module sbb_mean #(
   parameter int WIN_DEPTH = 7
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic [$clog2(WIN_DEPTH*255+1)-1:0]  sum_b,
   input  logic [$clog2(WIN_DEPTH*255+1)-1:0]  sum_g,
   input  logic [$clog2(WIN_DEPTH*255+1)-1:0]  sum_r,
   input  logic [$clog2(WIN_DEPTH+1)-1:0]      count,
   output logic [sbb_pkg::PIX_W-1:0]           mean_ff
);
   import sbb_pkg::*;

   localparam int SUMW  = $clog2(WIN_DEPTH*255+1);
   localparam int PRODW = SUMW + RECIP_W;

   logic [RECIP_W-1:0] recip;
   logic [PRODW-1:0]   prod_b, prod_g, prod_r;
   logic [PIX_W-1:0]   mean_in;

   always_comb begin
      recip   = recip_value(5'(count));
      prod_b  = PRODW'(sum_b) * PRODW'(recip);
      prod_g  = PRODW'(sum_g) * PRODW'(recip);
      prod_r  = PRODW'(sum_r) * PRODW'(recip);
      mean_in = {prod_r[RECIP_SHIFT +: 8], prod_g[RECIP_SHIFT +: 8], prod_b[RECIP_SHIFT +: 8]};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mean_ff <= mean_in;
      end
   end

endmodule

[src/separable_box_blur_stream_top.sv]
// Streaming separable box blur over a raster region with a column-wide line store.
//
// req channel carries one item per transfer: a pixel (tuser = 0) or a drain tick
// (tuser = 1). rsp channel returns blurred pixels; tlast marks the last result of
// an item, tuser marks the final pixel of the region. csr_we writes region_width
// (index 0) or region_height (index 1) and restarts the stream.
// Output row r is produced while input row r+BLUR_RADIUS arrives; once the region
// is complete, each drain tick returns one pending pixel in raster order.
// One item is handled at a time and is taken in the idle cycle. A pixel that
// finishes no column stays idle. A finished column adds horizontal sum, divide
// and line-store update in the first BLUR_RADIUS rows, and vertical divide and
// output once it emits, plus the wait for rsp_tready; the last column of a row
// finishes up to BLUR_RADIUS+1 columns. A drain tick adds read, vertical sum,
// divide, output and the wait. The line store is one entry per column holding all
// 2*BLUR_RADIUS+1 rows, read once and written back once per finished column.
// Reset clears counters and window, sets both sizes to 1; the line store is not
// cleared. While rsp_tready is low the result holds and req_tready stays low.
`timescale 1ns / 1ps
module separable_box_blur_stream_top #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int BLUR_RADIUS = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,   // in_blue, in_green, in_red
   input  logic                       req_tuser,   // func
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [55:0]                rsp_tdata,   // out_blue, out_green, out_red,
                                                   // out_alpha, out_col, out_row
   output logic                       rsp_tlast,
   output logic                       rsp_tuser,   // region_done
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [sbb_pkg::REG_W-1:0]  csr_wdata
);
   import sbb_pkg::*;

   localparam int WIN  = 2*BLUR_RADIUS + 1;
   localparam int SW   = $clog2(WIN);
   localparam int NW   = $clog2(WIN+1);
   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int SUMW = $clog2(WIN*255+1);
   localparam logic [REG_W-1:0] RAD  = REG_W'(BLUR_RADIUS);
   localparam logic [REG_W-1:0] RAD2 = REG_W'(2*BLUR_RADIUS);

   state_type state_ff, state_in;

   logic [REG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [REG_W-1:0] in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [REG_W-1:0] drain_col_ff, drain_col_in, drain_row_ff, drain_row_in;
   logic [SW-1:0]    in_slot_ff, in_slot_in, drain_slot_ff, drain_slot_in;
   logic [PIX_W-1:0] win_ff [WIN];
   logic [PIX_W-1:0] win_in [WIN];
   logic [REG_W-1:0] c_ff, c_in, hi_ff, hi_in, x_ff, x_in, r_ff, r_in;
   logic [SW-1:0]    slot_ff, slot_in, vtop_ff, vtop_in;
   logic [NW-1:0]    vn_ff, vn_in, count_ff, count_in;
   logic             emit_ff, emit_in, drain_ff, drain_in;
   logic [SUMW-1:0]  sum_ff [3];
   logic [SUMW-1:0]  sum_in [3];

   logic [WIN*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [WIN*PIX_W-1:0] mem_q, mem_wdata;
   logic                 mem_we, mem_re, mean_load;
   logic [PIX_W-1:0]     mean_q;

   logic [REG_W-1:0] w_eff, h_eff;
   logic             accept, pix_ok, drn_ok, pix_any, col_last;

   always_comb begin
      if (width_ff == '0) w_eff = REG_W'(1);
      else if (int'(width_ff) > MAX_WIDTH) w_eff = REG_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = REG_W'(1);
      else if (int'(height_ff) > MAX_HEIGHT) h_eff = REG_W'(MAX_HEIGHT);
      else h_eff = height_ff;
   end

   always_comb begin
      accept   = req_tvalid && req_tready;
      pix_ok   = (in_row_ff < h_eff) && (in_col_ff < w_eff);
      drn_ok   = (in_row_ff >= h_eff) && (drain_row_ff < h_eff) && (drain_col_ff < w_eff);
      pix_any  = (in_col_ff + REG_W'(1) >= w_eff) || (in_col_ff >= RAD);
      col_last = (c_ff == hi_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == FUNC_PIXEL && pix_ok && pix_any) state_in = ST_HSUM;
            else if (accept && req_tuser == FUNC_DRAIN && drn_ok) state_in = ST_DREAD;
         end
         ST_DREAD: state_in = ST_VSUM;
         ST_HSUM:  state_in = ST_HDIV;
         ST_HDIV:  state_in = ST_VSUM;
         ST_VSUM: begin
            if (emit_ff) state_in = ST_VDIV;
            else if (col_last) state_in = ST_IDLE;
            else state_in = ST_HSUM;
         end
         ST_VDIV:  state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) state_in = col_last ? ST_IDLE : ST_HSUM;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      mem_re     = (state_ff == ST_HSUM) || (state_ff == ST_DREAD);
      mem_we     = (state_ff == ST_VSUM) && !drain_ff;
      mean_load  = (state_ff == ST_HDIV) || (state_ff == ST_VDIV);
      rsp_tdata  = {4'b0, r_ff[9:0], c_ff[9:0], ALPHA_OPAQUE,
                    mean_q[23:16], mean_q[15:8], mean_q[7:0]};
      rsp_tlast  = col_last;
      rsp_tuser  = (c_ff + REG_W'(1) == w_eff) && (r_ff + REG_W'(1) == h_eff);
   end

   // datapath
   always_comb begin
      logic [REG_W-1:0] x, y, a, hn, r0, r1, nd;
      logic [SW:0]      t, ns, ring_gap;
      logic [PIX_W-1:0] merged [WIN];

      width_in      = width_ff;
      height_in     = height_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      drain_col_in  = drain_col_ff;
      drain_row_in  = drain_row_ff;
      in_slot_in    = in_slot_ff;
      drain_slot_in = drain_slot_ff;
      win_in        = win_ff;
      c_in          = c_ff;
      hi_in         = hi_ff;
      x_in          = x_ff;
      r_in          = r_ff;
      slot_in       = slot_ff;
      vtop_in       = vtop_ff;
      vn_in         = vn_ff;
      count_in      = count_ff;
      emit_in       = emit_ff;
      drain_in      = drain_ff;
      sum_in        = sum_ff;
      mem_wdata     = mem_q;
      x = in_col_ff;
      y = in_row_ff;
      a = '0; hn = '0; r0 = '0; r1 = '0; nd = '0; t = '0; ns = '0; ring_gap = '0;
      for (int s = 0; s < WIN; s++) merged[s] = mem_q[s*PIX_W +: PIX_W];

      if (state_ff == ST_IDLE && accept && req_tuser == FUNC_PIXEL && pix_ok) begin
         for (int d = WIN-1; d > 0; d--) win_in[d] = win_ff[d-1];
         win_in[0] = req_tdata;
         if (x + REG_W'(1) >= w_eff) begin
            c_in  = (x >= RAD) ? x - RAD : '0;
            hi_in = x;
         end else begin
            c_in  = x - RAD;
            hi_in = x - RAD;
         end
         x_in     = x;
         r_in     = y - RAD;
         slot_in  = in_slot_ff;
         vtop_in  = in_slot_ff;
         vn_in    = (y >= RAD2) ? NW'(WIN) : NW'(y + REG_W'(1));
         emit_in  = (y >= RAD);
         drain_in = 1'b0;
         if (x + REG_W'(1) >= w_eff) begin
            in_col_in  = '0;
            in_row_in  = y + REG_W'(1);
            ns         = (in_slot_ff == SW'(WIN-1)) ? '0 : (SW+1)'(in_slot_ff) + 1'b1;
            in_slot_in = SW'(ns);
            if (y + REG_W'(1) >= h_eff) begin
               in_row_in    = h_eff;
               drain_col_in = '0;
               if (h_eff > RAD) begin
                  drain_row_in  = h_eff - RAD;
                  drain_slot_in = (ns >= (SW+1)'(BLUR_RADIUS)) ? SW'(ns - (SW+1)'(BLUR_RADIUS))
                                  : SW'(ns + (SW+1)'(WIN - BLUR_RADIUS));
               end else begin
                  drain_row_in  = '0;
                  drain_slot_in = '0;
               end
            end
         end else begin
            in_col_in = x + REG_W'(1);
         end
      end

      if (state_ff == ST_IDLE && accept && req_tuser == FUNC_DRAIN && drn_ok) begin
         c_in     = drain_col_ff;
         hi_in    = drain_col_ff;
         r_in     = drain_row_ff;
         emit_in  = 1'b1;
         drain_in = 1'b1;
         r0 = (drain_row_ff >= RAD) ? drain_row_ff - RAD : '0;
         r1 = (drain_row_ff + RAD > h_eff - REG_W'(1)) ? h_eff - REG_W'(1) : drain_row_ff + RAD;
         vn_in   = NW'(r1 - r0 + REG_W'(1));
         nd      = r1 - drain_row_ff;
         t       = (SW+1)'(drain_slot_ff) + (SW+1)'(nd);
         vtop_in = (t >= (SW+1)'(WIN)) ? SW'(t - (SW+1)'(WIN)) : SW'(t);
         if (drain_col_ff + REG_W'(1) >= w_eff) begin
            drain_col_in  = '0;
            drain_row_in  = drain_row_ff + REG_W'(1);
            drain_slot_in = (drain_slot_ff == SW'(WIN-1)) ? '0 : drain_slot_ff + 1'b1;
            if (drain_row_ff + REG_W'(1) >= h_eff) begin
               in_col_in     = '0;
               in_row_in     = '0;
               drain_col_in  = '0;
               drain_row_in  = '0;
               in_slot_in    = '0;
               drain_slot_in = '0;
            end
         end else begin
            drain_col_in = drain_col_ff + REG_W'(1);
         end
      end

      if (state_ff == ST_HSUM) begin
         a  = (c_ff >= RAD) ? c_ff - RAD : '0;
         hn = x_ff - a + REG_W'(1);
         count_in = NW'(hn);
         for (int k = 0; k < 3; k++) sum_in[k] = '0;
         for (int d = 0; d < WIN; d++) begin
            if (REG_W'(d) < hn) begin
               for (int k = 0; k < 3; k++) sum_in[k] = sum_in[k] + SUMW'(win_ff[d][k*8 +: 8]);
            end
         end
      end

      if (state_ff == ST_VSUM) begin
         if (!drain_ff) merged[slot_ff] = mean_q;
         for (int s = 0; s < WIN; s++) mem_wdata[s*PIX_W +: PIX_W] = merged[s];
         count_in = vn_ff;
         for (int k = 0; k < 3; k++) sum_in[k] = '0;
         for (int s = 0; s < WIN; s++) begin
            ring_gap = (vtop_ff >= SW'(s)) ? (SW+1)'(vtop_ff) - (SW+1)'(s)
                       : (SW+1)'(vtop_ff) + (SW+1)'(WIN - s);
            if (ring_gap < (SW+1)'(vn_ff)) begin
               for (int k = 0; k < 3; k++) sum_in[k] = sum_in[k] + SUMW'(merged[s][k*8 +: 8]);
            end
         end
      end

      if ((state_ff == ST_VSUM && !emit_ff && !col_last) ||
          (state_ff == ST_OUT && rsp_tready && !col_last)) begin
         c_in = c_ff + REG_W'(1);
      end

      if (csr_we) begin
         unique case (csr_addr)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
         in_col_in     = '0;
         in_row_in     = '0;
         drain_col_in  = '0;
         drain_row_in  = '0;
         in_slot_in    = '0;
         drain_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_ff      <= REG_W'(1);
         height_ff     <= REG_W'(1);
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         drain_col_ff  <= '0;
         drain_row_ff  <= '0;
         in_slot_ff    <= '0;
         drain_slot_ff <= '0;
         for (int d = 0; d < WIN; d++) win_ff[d] <= '0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         drain_col_ff  <= drain_col_in;
         drain_row_ff  <= drain_row_in;
         in_slot_ff    <= in_slot_in;
         drain_slot_ff <= drain_slot_in;
         win_ff        <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff     <= c_in;
      hi_ff    <= hi_in;
      x_ff     <= x_in;
      r_ff     <= r_in;
      slot_ff  <= slot_in;
      vtop_ff  <= vtop_in;
      vn_ff    <= vn_in;
      count_ff <= count_in;
      emit_ff  <= emit_in;
      drain_ff <= drain_in;
      sum_ff   <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[AW'(c_ff)] <= mem_wdata;
      if (mem_re) mem_q <= line_mem[AW'(c_ff)];
   end

   sbb_mean #(
      .WIN_DEPTH (WIN)
   ) u_mean (
      .clock   (clock),
      .load    (mean_load),
      .sum_b   (sum_ff[0]),
      .sum_g   (sum_ff[1]),
      .sum_r   (sum_ff[2]),
      .count   (count_ff),
      .mean_ff (mean_q)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input taken while result pending");

   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re)) else $error("line store read and write collide");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (c_ff <= hi_ff)) else $error("column past last finished");

endmodule
